// File: rtl/rsi_pkg.sv
`default_nettype none
package rsi_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W = 32;
   localparam int DIR_W = 18;
   localparam int RAD_W = 15;
   localparam int DIST_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int K_W = 33;
   localparam int DOT_W = 53;
   localparam int D_W = 84;
   localparam int ROOT_W = 42;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_idx_type;

   // classified word handed from front to back
   typedef struct packed {
      logic              miss;
      logic signed [DOT_W-1:0] b;
      logic [D_W-1:0]    d;
   } work_type;

   // one result word
   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
      logic              from_inside;
   } rslt_type;
endpackage
`default_nettype wire

// File: rtl/rsi_front.sv
`default_nettype none
// Front: form k, b and the discriminant over five registered stages.
module rsi_front #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_x,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_y,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] origin_z,
   input  wire logic signed [rsi_pkg::DIR_W-1:0] dir_x,
   input  wire logic signed [rsi_pkg::DIR_W-1:0] dir_y,
   input  wire logic signed [rsi_pkg::DIR_W-1:0] dir_z,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] center_x,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] center_y,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] center_z,
   input  wire logic [rsi_pkg::RAD_W-1:0] radius,
   output logic out_valid,
   output rsi_pkg::work_type out_word
);
   localparam int KW = rsi_pkg::K_W;
   localparam int DW = rsi_pkg::DOT_W;
   localparam int SQ_W = 2 * KW;
   localparam int RS_W = rsi_pkg::RAD_W + FRAC_BITS;
   // |b| stays below 2^36; square it as 18-bit halves
   localparam int BMW = 36;
   localparam int HW = BMW / 2;

   logic [4:0] vld_ff, vld_in;
   // stage 1
   logic signed [KW-1:0] kx_ff, ky_ff, kz_ff;
   logic signed [rsi_pkg::DIR_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [RS_W-1:0] rs_ff;
   // stage 2
   logic signed [DW-1:0] px_ff, py_ff, pz_ff;
   logic [SQ_W-1:0] qx_ff, qy_ff, qz_ff;
   logic [2*RS_W-1:0] rr_ff;
   // stage 3
   logic signed [DW-1:0] b_ff, b_in;
   logic [rsi_pkg::D_W-1:0] kk_ff, rr3_ff;
   // stage 4
   logic signed [DW-1:0] b4_ff;
   logic [2*HW-1:0] hh_ff, hl_ff, ll_ff;
   logic [rsi_pkg::D_W-1:0] kk4_ff, rr4_ff;
   // stage 5
   logic signed [DW-1:0] b5_ff;
   logic [rsi_pkg::D_W-1:0] bb_ff, kk5_ff, rr5_ff;
   logic [rsi_pkg::D_W:0] pos;

   logic signed [DW-1:0] dot;
   logic [BMW-1:0] bmag;
   logic [HW-1:0] bh, bl;

   assign vld_in = {vld_ff[3:0], in_valid};
   assign dot = px_ff + py_ff + pz_ff;
   assign b_in = dot >>> FRAC_BITS;
   assign bmag = b_ff[DW-1] ? BMW'(-b_ff) : BMW'(b_ff);
   assign bh = bmag[BMW-1:HW];
   assign bl = bmag[HW-1:0];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      kx_ff <= KW'(origin_x) - KW'(center_x);
      ky_ff <= KW'(origin_y) - KW'(center_y);
      kz_ff <= KW'(origin_z) - KW'(center_z);
      dx_ff <= dir_x;
      dy_ff <= dir_y;
      dz_ff <= dir_z;
      rs_ff <= RS_W'(radius) << FRAC_BITS;
      px_ff <= DW'(dx_ff * kx_ff);
      py_ff <= DW'(dy_ff * ky_ff);
      pz_ff <= DW'(dz_ff * kz_ff);
      qx_ff <= SQ_W'(kx_ff * kx_ff);
      qy_ff <= SQ_W'(ky_ff * ky_ff);
      qz_ff <= SQ_W'(kz_ff * kz_ff);
      rr_ff <= rs_ff * rs_ff;
      b_ff <= b_in;
      kk_ff <= rsi_pkg::D_W'(qx_ff) + rsi_pkg::D_W'(qy_ff) + rsi_pkg::D_W'(qz_ff);
      rr3_ff <= rsi_pkg::D_W'(rr_ff);
      // square b as partial products of its halves
      b4_ff <= b_ff;
      hh_ff <= bh * bh;
      hl_ff <= bh * bl;
      ll_ff <= bl * bl;
      kk4_ff <= kk_ff;
      rr4_ff <= rr3_ff;
      // combine the partial products
      b5_ff <= b4_ff;
      bb_ff <= (rsi_pkg::D_W'(hh_ff) << (2 * HW)) + (rsi_pkg::D_W'(hl_ff) << (HW + 1)) +
               rsi_pkg::D_W'(ll_ff);
      kk5_ff <= kk4_ff;
      rr5_ff <= rr4_ff;
   end

   assign pos = {1'b0, bb_ff} + {1'b0, rr5_ff};
   assign out_valid = vld_ff[4];
   always_comb begin
      out_word.b = b5_ff;
      out_word.miss = pos < {1'b0, kk5_ff};
      out_word.d = rsi_pkg::D_W'(pos - {1'b0, kk5_ff});
   end
endmodule
`default_nettype wire

// File: rtl/rsi_queue.sv
`default_nettype none
// Short queue between front and back.
module rsi_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   input  wire rsi_pkg::work_type wr_word,
   output logic rd_valid,
   input  wire logic rd_ready,
   output rsi_pkg::work_type rd_word
);
   localparam int AW = $clog2(rsi_pkg::QUEUE_DEPTH);
   rsi_pkg::work_type mem_ff [rsi_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic rd_fire;

   assign rd_valid = cnt_ff != '0;
   assign rd_fire = rd_valid && rd_ready;
   assign rd_word = mem_ff[rp_ff];

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_valid) wp_ff <= wp_ff + 1'b1;
         if (rd_fire) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(wr_valid) - (AW+1)'(rd_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) mem_ff[wp_ff] <= wr_word;
   end
endmodule
`default_nettype wire

// File: rtl/rsi_back.sv
`default_nettype none
// Back: pipelined square root, one result bit per stage, then pick root.
module rsi_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire rsi_pkg::work_type in_word,
   output logic out_valid,
   output rsi_pkg::rslt_type out_word
);
   localparam int RW = rsi_pkg::ROOT_W;
   localparam int DW = rsi_pkg::D_W;
   localparam int BW = rsi_pkg::DOT_W;
   localparam int NS = RW;

   // remainder method: per stage one root bit
   logic [NS:0] vld_ff;
   logic [NS:0] miss_ff;
   logic signed [BW-1:0] b_ff [NS+1];
   logic [DW-1:0] x_ff [NS+1];
   logic [DW-1:0] rem_ff [NS+1];
   logic [RW-1:0] root_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[NS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      miss_ff[0] <= in_word.miss;
      b_ff[0] <= in_word.b;
      x_ff[0] <= in_word.d;
      rem_ff[0] <= '0;
      root_ff[0] <= '0;
   end

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [DW+1:0] trial, r2;
      always_comb begin
         r2 = {rem_ff[g], x_ff[g][DW-1:DW-2]};
         trial = (DW+2)'({root_ff[g], 2'b01});
      end
      always_ff @(posedge clock) begin
         miss_ff[g+1] <= miss_ff[g];
         b_ff[g+1] <= b_ff[g];
         x_ff[g+1] <= {x_ff[g][DW-3:0], 2'b00};
         if (r2 >= trial) begin
            rem_ff[g+1] <= DW'(r2 - trial);
            root_ff[g+1] <= {root_ff[g][RW-2:0], 1'b1};
         end else begin
            rem_ff[g+1] <= DW'(r2);
            root_ff[g+1] <= {root_ff[g][RW-2:0], 1'b0};
         end
      end
   end

   // select nearest non-negative root
   logic signed [BW+1:0] s, nb, t1, t2, t;
   always_comb begin
      s = (BW+2)'($signed({1'b0, root_ff[NS]}));
      nb = -(BW+2)'(b_ff[NS]);
      t1 = nb - s;
      t2 = nb + s;
      t = t1[BW+1] ? t2 : t1;
      out_valid = vld_ff[NS];
      out_word.hit = !miss_ff[NS] && !t2[BW+1];
      out_word.from_inside = out_word.hit && t1[BW+1];
      if (!out_word.hit) out_word.distance = '0;
      else if (t > (BW+2)'(33'h0FFFFFFFF)) out_word.distance = '1;
      else out_word.distance = t[rsi_pkg::DIST_W-1:0];
   end
endmodule
`default_nettype wire

// File: rtl/ray_sphere_intersect_top.sv
`default_nettype none
// Ray/sphere test. Rays enter one per cycle (busy never rises); each gives one
// result strobe on rsp_valid, raised once the ray has passed the 5 front stages
// forming k, b and the discriminant, 1 queue stage, the back's input register,
// 42 square-root stages (one root bit per stage) and the output register, the
// first of them loaded by the accepting edge. The receiver cannot stall.
// Write sphere registers through csr_ only while no ray is in flight.
module ray_sphere_intersect_top #(
   parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] req_origin_x,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] req_origin_y,
   input  wire logic signed [rsi_pkg::COORD_W-1:0] req_origin_z,
   input  wire logic signed [rsi_pkg::DIR_W-1:0] req_dir_x,
   input  wire logic signed [rsi_pkg::DIR_W-1:0] req_dir_y,
   input  wire logic signed [rsi_pkg::DIR_W-1:0] req_dir_z,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic [rsi_pkg::DIST_W-1:0] rsp_distance,
   output logic rsp_from_inside,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [rsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rsi_pkg::COORD_W-1:0] csr_wdata
);
   logic signed [rsi_pkg::COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [rsi_pkg::RAD_W-1:0] rad_ff;
   logic f_valid, q_valid, b_valid, vld_ff;
   rsi_pkg::work_type f_word, q_word;
   rsi_pkg::rslt_type b_word, rs_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // hold sphere registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         rad_ff <= rsi_pkg::RAD_W'(1);
      end else if (csr_valid) begin
         case (rsi_pkg::csr_idx_type'(csr_index))
            rsi_pkg::CSR_CENTER_X: cx_ff <= csr_wdata;
            rsi_pkg::CSR_CENTER_Y: cy_ff <= csr_wdata;
            rsi_pkg::CSR_CENTER_Z: cz_ff <= csr_wdata;
            rsi_pkg::CSR_RADIUS:   rad_ff <= csr_wdata[rsi_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   rsi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(start && !busy),
      .origin_x(req_origin_x), .origin_y(req_origin_y), .origin_z(req_origin_z),
      .dir_x(req_dir_x), .dir_y(req_dir_y), .dir_z(req_dir_z),
      .center_x(cx_ff), .center_y(cy_ff), .center_z(cz_ff), .radius(rad_ff),
      .out_valid(f_valid), .out_word(f_word)
   );

   rsi_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_word(f_word),
      .rd_valid(q_valid), .rd_ready(1'b1), .rd_word(q_word)
   );

   rsi_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_word(q_word),
      .out_valid(b_valid), .out_word(b_word)
   );

   // register the result word
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= b_valid;
      rs_ff <= b_word;
   end

   assign rsp_valid = vld_ff;
   assign rsp_hit = rs_ff.hit;
   assign rsp_distance = rs_ff.distance;
   assign rsp_from_inside = rs_ff.from_inside;

`ifndef NO_ASSERTIONS
   a_inside_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_inside |-> rsp_hit) else $error("inside without hit");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_distance == '0) else $error("miss distance");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      b_valid |=> rsp_valid) else $error("lost word");
`endif
endmodule
`default_nettype wire
